/* hw/rtl/pbfa_pkg.sv */
// shared types, codes and constants of the packed bit-field array
`timescale 1ns / 1ps
package pbfa_pkg;

    localparam int STORE_BYTES_DEF = 1024;
    localparam int MAX_WIDTH_DEF   = 32;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 4;
    localparam int IDX_W  = 13;
    localparam int CNT_W  = 14;
    localparam int EW_W   = 6;
    localparam int UB_W   = 11;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_GET  = 4'd0;
    localparam logic [REQ_W-1:0] REQ_SET  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_ADD  = 4'd2;
    localparam logic [REQ_W-1:0] REQ_SUB  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_MUL  = 4'd4;
    localparam logic [REQ_W-1:0] REQ_DIV  = 4'd5;
    localparam logic [REQ_W-1:0] REQ_MOD  = 4'd6;
    localparam logic [REQ_W-1:0] REQ_INC  = 4'd7;
    localparam logic [REQ_W-1:0] REQ_DEC  = 4'd8;
    localparam logic [REQ_W-1:0] REQ_FILL = 4'd9;

    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_USED  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_DIVZ = 2'd2
    } t_stat;

    typedef struct packed {
        logic load_req;
        logic div_start;
        logic div_cnt;
        logic cnt_load;
        logic set_oob;
        logic set_fill;
        logic fill_init;
        logic fill_next;
        logic rd_hi;
        logic cap_lo;
        logic cap_hi;
        logic ext;
        logic op_exec;
        logic div_load;
        logic wr_en;
        logic wr_hi;
        logic out_load;
        logic clr_wr;
    } t_cmd;

    typedef struct packed {
        logic is_fill;
        logic oob;
        logic cnt_zero;
        logic fill_last;
        logic is_div;
        logic opv_zero;
        logic div_done;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/pbfa_div.sv */
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pbfa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pbfa_pkg::DATA_W-1:0]  i_dividend,
    input  logic [pbfa_pkg::DATA_W-1:0]  i_divisor,
    output logic [pbfa_pkg::DATA_W-1:0]  o_quo,
    output logic [pbfa_pkg::DATA_W-1:0]  o_rem,
    output logic                         o_done
);
    localparam int DW = pbfa_pkg::DATA_W;
    localparam int SW = $clog2(DW);

    logic [DW-1:0] r_q;
    logic [DW-1:0] r_r;
    logic [DW-1:0] r_d;
    logic [SW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] n_r;
    logic          qbit;

    always_comb begin
        trial = {r_r, r_q[DW-1]};
        diff  = trial - {1'b0, r_d};
        qbit  = ~diff[DW];
        n_r   = qbit ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DW-2:0], qbit};
            r_r <= n_r;
        end
    end

    assign o_quo  = r_q;
    assign o_rem  = r_r;
    assign o_done = r_done;
endmodule

/* hw/rtl/pbfa_dpath.sv */
// datapath: word store, element extract and merge, arithmetic, result register
`timescale 1ns / 1ps
module pbfa_dpath #(
    parameter int STORE_BYTES = pbfa_pkg::STORE_BYTES_DEF,
    parameter int MAX_WIDTH   = pbfa_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_index,
    input  logic [pbfa_pkg::UB_W-1:0]     i_cfg_data,
    input  logic [pbfa_pkg::REQ_W-1:0]    i_req_type,
    input  logic [pbfa_pkg::IDX_W-1:0]    i_element_index,
    input  logic [pbfa_pkg::DATA_W-1:0]   i_operand_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [pbfa_pkg::DATA_W-1:0]   o_element_value,
    output logic [pbfa_pkg::STAT_W-1:0]   o_status,
    input  pbfa_pkg::t_cmd                i_cmd,
    output pbfa_pkg::t_sts                o_sts
);
    localparam int DW    = pbfa_pkg::DATA_W;
    localparam int CW    = pbfa_pkg::CNT_W;
    localparam int EW    = pbfa_pkg::EW_W;
    localparam int UW    = pbfa_pkg::UB_W;
    localparam int WORDS = (STORE_BYTES + 3) / 4;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = CW + EW;
    localparam logic [16:0] SB = 17'(STORE_BYTES);

    logic [DW-1:0] mem [WORDS];
    logic [DW-1:0] r_rdata;

    logic [EW-1:0]              r_ew;
    logic [UW-1:0]              r_ub;
    logic [pbfa_pkg::REQ_W-1:0] r_req;
    logic [CW-1:0]              r_idx;
    logic [DW-1:0]              r_opv;
    logic [CW-1:0]              r_count;
    logic [DW-1:0]              r_lo;
    logic [DW-1:0]              r_hi;
    logic [DW-1:0]              r_cur;
    logic [DW-1:0]              r_nv;
    pbfa_pkg::t_stat            r_stat;
    logic [AW-1:0]              r_clr;
    logic                       r_out_valid;
    logic [DW-1:0]              r_out_val;
    pbfa_pkg::t_stat            r_out_stat;

    logic [EW-1:0]   w6;
    logic [DW-1:0]   mask;
    logic [UW-1:0]   ub;
    logic [BW-1:0]   base;
    logic [BW-6:0]   w0;
    logic [BW-5:0]   w1;
    logic            w1_ok;
    logic [AW-1:0]   addr0;
    logic [AW-1:0]   addr1;
    logic [4:0]      off;
    logic [2*DW-1:0] window;
    logic [2*DW-1:0] sh_mask;
    logic [2*DW-1:0] sh_val;
    logic [2*DW-1:0] merged;
    logic [DW-1:0]   nvm;
    logic [DW-1:0]   cur_ext;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [DW-1:0]   wr_data;
    logic            wr_go;
    logic [DW-1:0]   div_dvd;
    logic [DW-1:0]   div_dsr;
    logic [DW-1:0]   div_quo;
    logic [DW-1:0]   div_rem;
    logic            div_done;

    always_comb begin
        if (r_ew == '0) begin
            w6 = EW'(1);
        end else if (r_ew > EW'(MAX_WIDTH)) begin
            w6 = EW'(MAX_WIDTH);
        end else begin
            w6 = r_ew;
        end
        mask    = (w6 >= EW'(DW)) ? '1 : ((DW'(1) << w6) - DW'(1));
        ub      = ({6'd0, r_ub} > SB) ? SB[UW-1:0] : r_ub;
        base    = BW'(r_idx) * BW'(w6);
        w0      = base[BW-1:5];
        w1      = (BW-4)'(w0) + 1'b1;
        w1_ok   = 17'(w1) < 17'(WORDS);
        addr0   = w0[AW-1:0];
        addr1   = w1_ok ? w1[AW-1:0] : addr0;
        off     = base[4:0];
        window  = {r_hi, r_lo};
        cur_ext = window[DW-1+:1] == 1'b0 ? DW'(window >> off) & mask
                                          : DW'(window >> off) & mask;
        nvm     = r_nv & mask;
        sh_mask = {{DW{1'b0}}, mask} << off;
        sh_val  = {{DW{1'b0}}, nvm} << off;
        merged  = (window & ~sh_mask) | sh_val;
        rd_addr = i_cmd.rd_hi ? addr1 : addr0;
        if (i_cmd.clr_wr) begin
            wr_addr = r_clr;
            wr_data = '0;
        end else if (i_cmd.wr_hi) begin
            wr_addr = addr1;
            wr_data = merged[2*DW-1:DW];
        end else begin
            wr_addr = addr0;
            wr_data = merged[DW-1:0];
        end
        wr_go   = i_cmd.clr_wr | (i_cmd.wr_en & (~i_cmd.wr_hi | w1_ok));
        div_dvd = i_cmd.div_cnt ? {18'd0, ub, 3'd0} : r_cur;
        div_dsr = i_cmd.div_cnt ? DW'(w6) : r_opv;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
        if (wr_go) begin
            mem[wr_addr] <= wr_data;
        end
    end

    pbfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_quo      (div_quo),
        .o_rem      (div_rem),
        .o_done     (div_done)
    );

    // configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ew        <= EW'(8);
            r_ub        <= UW'(1024);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en && i_cfg_index == pbfa_pkg::CFG_WIDTH) begin
                r_ew <= i_cfg_data[EW-1:0];
            end
            if (i_cfg_wr_en && i_cfg_index == pbfa_pkg::CFG_USED) begin
                r_ub <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_type;
            r_idx <= CW'(i_element_index);
            r_opv <= i_operand_value;
        end else if (i_cmd.fill_init) begin
            r_idx <= '0;
        end else if (i_cmd.fill_next) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.cnt_load) begin
            r_count <= div_quo[CW-1:0];
        end
        if (i_cmd.cap_lo) begin
            r_lo <= r_rdata;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= w1_ok ? r_rdata : '0;
        end
        if (i_cmd.ext) begin
            r_cur <= cur_ext;
        end
        if (i_cmd.set_oob) begin
            r_nv   <= '0;
            r_stat <= pbfa_pkg::ST_OOB;
        end else if (i_cmd.set_fill) begin
            r_nv   <= r_opv;
            r_stat <= pbfa_pkg::ST_OK;
        end else if (i_cmd.div_load) begin
            r_nv <= (r_req == pbfa_pkg::REQ_DIV) ? div_quo : div_rem;
        end else if (i_cmd.op_exec) begin
            r_stat <= pbfa_pkg::ST_OK;
            case (r_req)
                pbfa_pkg::REQ_SET:  r_nv <= r_opv;
                pbfa_pkg::REQ_ADD:  r_nv <= r_cur + r_opv;
                pbfa_pkg::REQ_SUB:  r_nv <= r_cur - r_opv;
                pbfa_pkg::REQ_MUL:  r_nv <= r_cur * r_opv;
                pbfa_pkg::REQ_DIV,
                pbfa_pkg::REQ_MOD: begin
                    r_nv <= r_cur;
                    if (r_opv == '0) begin
                        r_stat <= pbfa_pkg::ST_DIVZ;
                    end
                end
                pbfa_pkg::REQ_INC:  r_nv <= r_cur + 1'b1;
                pbfa_pkg::REQ_DEC:  r_nv <= r_cur - 1'b1;
                pbfa_pkg::REQ_FILL: r_nv <= r_opv;
                default:            r_nv <= r_cur;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_val  <= nvm;
            r_out_stat <= r_stat;
        end
    end

    always_comb begin
        o_sts.is_fill   = r_req == pbfa_pkg::REQ_FILL;
        o_sts.oob       = r_idx >= r_count;
        o_sts.cnt_zero  = r_count == '0;
        o_sts.fill_last = CW'(r_idx + 1'b1) == r_count;
        o_sts.is_div    = (r_req == pbfa_pkg::REQ_DIV) || (r_req == pbfa_pkg::REQ_MOD);
        o_sts.opv_zero  = r_opv == '0;
        o_sts.div_done  = div_done;
        o_sts.clr_last  = r_clr == AW'(WORDS - 1);
        o_sts.out_free  = ~r_out_valid | i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_element_value = r_out_val;
    assign o_status        = r_out_stat;
endmodule

/* hw/rtl/pbfa_ctrl.sv */
// controller state machine sequencing each request over the datapath
`timescale 1ns / 1ps
module pbfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pbfa_pkg::t_sts i_sts,
    output pbfa_pkg::t_cmd o_cmd
);
    typedef enum logic [13:0] {
        S_CLR  = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_CNTW = 14'b00000000000100,
        S_CHK  = 14'b00000000001000,
        S_RD0  = 14'b00000000010000,
        S_RD1  = 14'b00000000100000,
        S_CAP  = 14'b00000001000000,
        S_EXT  = 14'b00000010000000,
        S_OP   = 14'b00000100000000,
        S_DIVW = 14'b00001000000000,
        S_WR0  = 14'b00010000000000,
        S_WR1  = 14'b00100000000000,
        S_DONE = 14'b01000000000000,
        S_SPR  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_dirty;
    logic   accept;

    assign accept     = (r_state == S_IDLE) & i_in_valid;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_req = 1'b1;
                    if (r_dirty) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_cnt   = 1'b1;
                        n_state         = S_CNTW;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CNTW: begin
                if (i_sts.div_done) begin
                    o_cmd.cnt_load = 1'b1;
                    n_state        = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.is_fill) begin
                    if (i_sts.cnt_zero) begin
                        o_cmd.set_fill = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.fill_init = 1'b1;
                        n_state         = S_RD0;
                    end
                end else if (i_sts.oob) begin
                    o_cmd.set_oob = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                o_cmd.cap_lo = 1'b1;
                o_cmd.rd_hi  = 1'b1;
                n_state      = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = S_EXT;
            end
            S_EXT: begin
                o_cmd.ext = 1'b1;
                n_state   = S_OP;
            end
            S_OP: begin
                o_cmd.op_exec = 1'b1;
                if (i_sts.is_div && !i_sts.opv_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVW;
                end else begin
                    n_state = S_WR0;
                end
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_WR0;
                end
            end
            S_WR0: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wr_hi = 1'b1;
                if (i_sts.is_fill && !i_sts.fill_last) begin
                    o_cmd.fill_next = 1'b1;
                    n_state         = S_RD0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SPR:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_dirty <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_dirty <= 1'b1;
            end else if (o_cmd.cnt_load) begin
                r_dirty <= 1'b0;
            end
        end
    end

    // the element count must be fresh before any range check
    a_cnt_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> !r_dirty)
        else $error("range check with stale element count");

    // a result is never loaded over one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result register overwritten");

    // no store write while the divider result is pending
    a_div_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVW) |-> !o_cmd.wr_en)
        else $error("store written during divide");
endmodule

/* hw/rtl/packed_bitfield_array_rmw_core.sv */
// top level of the packed bit-field array with read-modify-write requests
//
// Usage: one request item enters on the s_axis side (req_type in tuser,
// element_index and operand_value in tdata); exactly one result item leaves
// on the m_axis side (element_value in tdata, status in tuser). Element
// width and used bytes are set through the cfg write port; the user must
// write them only while idle, the block itself does not enforce it.
// Div and mod run on a 32-step bit-serial divider, and the first request
// after any config write first recomputes the element count on the same
// divider. A fill walks every element with a two-word read-modify-write.
// One request is in flight at a time; the next is accepted as soon as the
// result sits in the output register, even if the receiver stalls.
// After reset the store is swept to zero, one 32-bit word a cycle, all
// (STORE_BYTES+3)/4 words, with s_axis_tready low; config writes are taken.
`timescale 1ns / 1ps
module packed_bitfield_array_rmw_core #(
    parameter int STORE_BYTES = pbfa_pkg::STORE_BYTES_DEF,
    parameter int MAX_WIDTH   = pbfa_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // element_index[12:0], operand_value[44:13]
    input  logic [3:0]  s_axis_tuser,   // req_type[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // element_value[31:0]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    pbfa_pkg::t_cmd cmd;
    pbfa_pkg::t_sts sts;

    pbfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pbfa_dpath #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (s_axis_tuser),
        .i_element_index (s_axis_tdata[12:0]),
        .i_operand_value (s_axis_tdata[44:13]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_element_value (m_axis_tdata),
        .o_status        (m_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken while one is in flight");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == pbfa_pkg::ST_OOB) |-> (m_axis_tdata == '0))
        else $error("out-of-range result carries a value");

    a_rst_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("item accepted before store clear");
endmodule
